### sv/isb_pkg.sv
package isb_pkg;

    localparam int PALETTES_DEF    = 16;
    localparam int PAL_ENTRIES     = 256;
    localparam int MAX_IMAGE_SIDE  = 1024;
    localparam int MAX_CANVAS_SIDE = 16384;

    localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

    localparam int IDX_W   = 8;
    localparam int SRC_W   = 10;
    localparam int IMG_W   = 11;
    localparam int ORG_W   = 15;
    localparam int SIDE_W  = 15;
    localparam int POS_W   = 14;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 28;
    localparam int COLOR_W = 32;

    typedef enum logic [1:0] {
        CFG_CANVAS_WIDTH  = 2'd0,
        CFG_CANVAS_HEIGHT = 2'd1,
        CFG_PALETTE_COUNT = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_reg_t;

    // decoded view of one input word
    typedef struct packed {
        logic             ok;       // visible, non-transparent pixel inside its image
        logic             use_pal;  // color comes from palette memory
        logic             mem_we;   // palette write that lands in memory
        logic [IMG_W-1:0] xx;       // offset in sprite after flip
        logic [IMG_W-1:0] yy;
    } front_t;

endpackage

### sv/indexed_sprite_blitter_unit.sv
// Indexed sprite blitter: one input word per sprite pixel or palette entry load.
// Input channel: in_valid / in_stall with the item fields as separate ports.
// operation 0 blits a pixel, 1 stores entry_color in palette memory if palette_select < PALETTES.
// Output channel: out_valid / out_stall; every input word yields exactly one
// output word (write_enable, pixel_address, pixel_color) in input order.
// Throughput is one word per clock while out_stall is low: the single palette memory
// port serves either the lookup or the entry load of each word. A word passes
// through four register stages: memory read and flip, offset add and clip, row
// multiply, address add. Each stage holds only while it is full and the next
// stage cannot move, so in_stall rises only when all four stages hold words and
// out_stall is high. A stalled output word stays unchanged.
// The user writes configuration (cfg_write, cfg_index, cfg_data) only while the
// block is idle; the block does not enforce it. Reset clears the pipeline and
// sets the canvas to 1x1 with no palettes; palette memory is not cleared and
// must be loaded before it is used.
module indexed_sprite_blitter_unit #(
    parameter int PALETTES = isb_pkg::PALETTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [isb_pkg::SIDE_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [isb_pkg::IDX_W-1:0]           pixel_index,
    input  logic [isb_pkg::SRC_W-1:0]           src_x,
    input  logic [isb_pkg::SRC_W-1:0]           src_y,
    input  logic [isb_pkg::IMG_W-1:0]           image_width,
    input  logic [isb_pkg::IMG_W-1:0]           image_height,
    input  logic signed [isb_pkg::ORG_W-1:0]    origin_x,
    input  logic signed [isb_pkg::ORG_W-1:0]    origin_y,
    input  logic                                hflip,
    input  logic                                vflip,
    input  logic [7:0]                          palette_select,
    input  logic [isb_pkg::COLOR_W-1:0]         entry_color,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                write_enable,
    output logic [isb_pkg::ADDR_W-1:0]          pixel_address,
    output logic [isb_pkg::COLOR_W-1:0]         pixel_color
);
    import isb_pkg::*;

    localparam int PAL_AW = (PALETTES > 1) ? $clog2(PALETTES) : 1;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0)
            r = SIDE_W'(1);
        else if (v > SIDE_W'(MAX_CANVAS_SIDE))
            r = SIDE_W'(MAX_CANVAS_SIDE);
        else
            r = v;
        return r;
    endfunction

    // configuration
    logic [SIDE_W-1:0] canvas_w_reg;
    logic [SIDE_W-1:0] canvas_h_reg;
    logic [CNT_W-1:0]  palette_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w_reg      <= SIDE_W'(1);
            canvas_h_reg      <= SIDE_W'(1);
            palette_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_CANVAS_WIDTH:  canvas_w_reg      <= clamp_side(cfg_data);
                CFG_CANVAS_HEIGHT: canvas_h_reg      <= clamp_side(cfg_data);
                CFG_PALETTE_COUNT: palette_count_reg <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // stage enables, back to front
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, en_out;
    logic accept;

    assign en_out   = !out_valid_reg || !out_stall;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en_out)
                out_valid_reg <= v3_reg;
        end
    end

    // stage 1: decode, palette read or write
    front_t                       front;
    logic [PAL_AW+IDX_W-1:0]      mem_addr;
    logic [COLOR_W-1:0]           mem_rdata;

    isb_front #(
        .PALETTES (PALETTES),
        .PAL_AW   (PAL_AW)
    ) u_front (
        .operation      (operation),
        .pixel_index    (pixel_index),
        .src_x          (src_x),
        .src_y          (src_y),
        .image_width    (image_width),
        .image_height   (image_height),
        .hflip          (hflip),
        .vflip          (vflip),
        .palette_select (palette_select),
        .palette_count  (palette_count_reg),
        .front          (front),
        .mem_addr       (mem_addr)
    );

    // one item per cycle unless stalled; a write word also reads, but that data goes unused
    isb_palette_mem #(
        .PALETTES (PALETTES),
        .PAL_AW   (PAL_AW)
    ) u_mem (
        .clk   (clk),
        .we    (accept && front.mem_we),
        .re    (en1),
        .addr  (mem_addr),
        .wdata (entry_color),
        .rdata (mem_rdata)
    );

    logic               ok1_reg;
    logic               use_pal1_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic [IMG_W-1:0]   xx1_reg;
    logic [IMG_W-1:0]   yy1_reg;
    logic [ORG_W-1:0]   ox1_reg;
    logic [ORG_W-1:0]   oy1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ok1_reg      <= front.ok;
            use_pal1_reg <= front.use_pal;
            idx1_reg     <= pixel_index;
            xx1_reg      <= front.xx;
            yy1_reg      <= front.yy;
            ox1_reg      <= origin_x;
            oy1_reg      <= origin_y;
        end
    end

    // stage 2: canvas position, clip, color select
    logic [ORG_W:0]     dx_sum;
    logic [ORG_W:0]     dy_sum;
    logic               in_canvas;
    logic               we2_next;
    logic [COLOR_W-1:0] color2_next;

    assign dx_sum = {ox1_reg[ORG_W-1], ox1_reg} + (ORG_W+1)'(xx1_reg);
    assign dy_sum = {oy1_reg[ORG_W-1], oy1_reg} + (ORG_W+1)'(yy1_reg);

    assign in_canvas = !dx_sum[ORG_W] && !dy_sum[ORG_W]
                       && (dx_sum[ORG_W-1:0] < canvas_w_reg)
                       && (dy_sum[ORG_W-1:0] < canvas_h_reg);
    assign we2_next  = ok1_reg && in_canvas;

    always_comb
    begin
        if (!we2_next)
            color2_next = '0;
        else if (use_pal1_reg)
            color2_next = mem_rdata;
        else
            color2_next = {OPAQUE_ALPHA, idx1_reg, idx1_reg, idx1_reg};
    end

    logic               we2_reg;
    logic [POS_W-1:0]   dx2_reg;
    logic [POS_W-1:0]   dy2_reg;
    logic [COLOR_W-1:0] color2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            we2_reg    <= we2_next;
            dx2_reg    <= dx_sum[POS_W-1:0];
            dy2_reg    <= dy_sum[POS_W-1:0];
            color2_reg <= color2_next;
        end
    end

    // stage 3: row offset
    logic               we3_reg;
    logic [ADDR_W-1:0]  prod3_reg;
    logic [POS_W-1:0]   dx3_reg;
    logic [COLOR_W-1:0] color3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            we3_reg    <= we2_reg;
            prod3_reg  <= ADDR_W'(dy2_reg) * ADDR_W'(canvas_w_reg);
            dx3_reg    <= dx2_reg;
            color3_reg <= color2_reg;
        end
    end

    // output word
    logic               we_out_reg;
    logic [ADDR_W-1:0]  addr_out_reg;
    logic [COLOR_W-1:0] color_out_reg;
    logic [ADDR_W-1:0]  addr_next;

    assign addr_next = we3_reg ? (prod3_reg + ADDR_W'(dx3_reg)) : '0;

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            we_out_reg    <= we3_reg;
            addr_out_reg  <= addr_next;
            color_out_reg <= color3_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = we_out_reg;
    assign pixel_address = addr_out_reg;
    assign pixel_color   = color_out_reg;

    // input backs up only with every stage full and the output held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && out_valid_reg && out_stall))
        else $error("in_stall with a free pipeline stage");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (pixel_address == '0 && pixel_color == '0))
        else $error("non-write word carries address or color");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_enable) |->
            ({1'b0, pixel_address} < (29'(canvas_w_reg) * 29'(canvas_h_reg))))
        else $error("canvas address beyond canvas");

    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("word lost between row stage and output");

endmodule

### sv/isb_front.sv
module isb_front #(
    parameter int PALETTES = isb_pkg::PALETTES_DEF,
    parameter int PAL_AW   = 4
) (
    input  logic                         operation,
    input  logic [isb_pkg::IDX_W-1:0]    pixel_index,
    input  logic [isb_pkg::SRC_W-1:0]    src_x,
    input  logic [isb_pkg::SRC_W-1:0]    src_y,
    input  logic [isb_pkg::IMG_W-1:0]    image_width,
    input  logic [isb_pkg::IMG_W-1:0]    image_height,
    input  logic                         hflip,
    input  logic                         vflip,
    input  logic [7:0]                   palette_select,
    input  logic [isb_pkg::CNT_W-1:0]    palette_count,
    output isb_pkg::front_t              front,
    output logic [PAL_AW+isb_pkg::IDX_W-1:0] mem_addr
);
    import isb_pkg::*;

    logic iw_ok;
    logic ih_ok;
    logic sx_ok;
    logic sy_ok;
    logic pal_in_mem;

    assign iw_ok = (image_width != '0) && (image_width <= IMG_W'(MAX_IMAGE_SIDE));
    assign ih_ok = (image_height != '0) && (image_height <= IMG_W'(MAX_IMAGE_SIDE));
    assign sx_ok = {1'b0, src_x} < image_width;
    assign sy_ok = {1'b0, src_y} < image_height;

    assign pal_in_mem = {1'b0, palette_select} < 9'(PALETTES);

    always_comb
    begin
        front.ok      = !operation && iw_ok && ih_ok && sx_ok && sy_ok
                        && (pixel_index != '0);
        front.use_pal = pal_in_mem && (palette_select < {3'b000, palette_count});
        front.mem_we  = operation && pal_in_mem;
        // mirrored offset only matters when the source position is inside the image
        front.xx      = hflip ? (image_width - IMG_W'(1) - {1'b0, src_x}) : {1'b0, src_x};
        front.yy      = vflip ? (image_height - IMG_W'(1) - {1'b0, src_y}) : {1'b0, src_y};
    end

    assign mem_addr = {palette_select[PAL_AW-1:0], pixel_index};

endmodule

### sv/isb_palette_mem.sv
module isb_palette_mem #(
    parameter int PALETTES = isb_pkg::PALETTES_DEF,
    parameter int PAL_AW   = 4
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic                               re,
    input  logic [PAL_AW+isb_pkg::IDX_W-1:0]   addr,
    input  logic [isb_pkg::COLOR_W-1:0]        wdata,
    output logic [isb_pkg::COLOR_W-1:0]        rdata
);
    import isb_pkg::*;

    localparam int DEPTH = PALETTES * PAL_ENTRIES;

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
